>>> rtl/eppm_pkg.sv
// eppm_pkg: shared types and constants for the eased point-to-point mover
// no dependencies; used by eased_point_to_point_mover
`timescale 1ns / 1ps

package eppm_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int SPEED_W = 16;
  localparam int BRAKE_W = 23;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 16'd1536;
  localparam logic [SPEED_W-1:0] ACCEL_STEP_RST = 16'd51;
  localparam logic [BRAKE_W-1:0] BRAKE_ZONE_RST = 23'd7680;
  localparam logic [SPEED_W-1:0] SNAP_DIST_RST = 16'd512;

  typedef enum logic [1:0] {
    REG_CRUISE_SPEED,
    REG_ACCEL_STEP,
    REG_BRAKE_ZONE,
    REG_SNAP_DIST
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SQX,
    ST_SQY,
    ST_TEST,
    ST_TGTMUL,
    ST_TGTDIV,
    ST_SPEED,
    ST_ROOT,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_OUT
  } state_t;

endpackage

>>> rtl/eased_point_to_point_mover.sv
// eased_point_to_point_mover: stepping a 2d position toward a target with eased speed
// depends on eppm_pkg; serial multiplier, restoring divider and square root inside
// input beat: s_tuser = kind, s_tdata = target_x, target_y
// output beat: m_tdata = pos_x, pos_y, speed_now; m_tuser = arrived
// configuration over an apb-style port: cruise_speed, accel_step, brake_zone, snap_distance
// (byte addresses 0, 4, 8, 12); pready is always high, reads return the register
// one beat in gives exactly one beat out; the block takes one beat at a time
// a place command (kind 1) loads the position and goes straight to the output state; a
// step is computed by a shift-add multiplier retiring one multiplier bit per cycle, a
// restoring divider retiring one quotient bit per cycle and a square root retiring one
// root bit per cycle, all run in turn; the next beat is taken in the cycle after the
// result is registered
// reset (synchronous, active high) clears position and speed to zero and loads the
// register defaults; it also drops any beat still held at the output
// the result sits in an output register; while the receiver stalls the finished
// beat holds, the block can still accept the next beat and then waits before
// presenting the next result
`timescale 1ns / 1ps

module eased_point_to_point_mover #(
  parameter int COORD_WIDTH = eppm_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // target_x, target_y, zero fill
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  // kind
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pos_x, pos_y, speed_now, zero fill
  output logic [((2*COORD_WIDTH+16+7)/8)*8-1:0]  m_tdata,
  // arrived
  output logic                                   m_tuser,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [eppm_pkg::CFG_AW-1:0]            paddr,
  input  logic [eppm_pkg::CFG_DW-1:0]            pwdata,
  output logic [eppm_pkg::CFG_DW-1:0]            prdata,
  output logic                                   pready
);

  localparam int W = COORD_WIDTH;
  localparam int SPW = eppm_pkg::SPEED_W;
  localparam int BZW = eppm_pkg::BRAKE_W;
  localparam int DW = W + 1;             // delta magnitude
  localparam int SW = 2 * W + 2;         // squared distance
  localparam int PW = SW + SPW;          // product accumulator
  localparam int B2W = 2 * BZW;          // brake zone squared
  localparam int DVW = (B2W > DW) ? B2W : DW;
  localparam int CMW = (B2W > SW) ? B2W : SW;
  localparam int QW = W + 2;             // axis step quotient
  localparam int RW = W + 1;             // root bits
  localparam int CW = $clog2(QW + 1);
  localparam int EW = W + 3;             // position update width
  localparam int OTW = ((2 * W + SPW + 7) / 8) * 8;

  eppm_pkg::state_t state, state_next;

  // configuration
  logic [SPW-1:0] cruise_speed, accel_step, snap_distance;
  logic [BZW-1:0] brake_zone;

  // architectural state
  logic signed [W-1:0] pos_x, pos_y;
  logic [SPW-1:0]      spd;
  logic                arrived;

  // working registers
  logic signed [W-1:0] tx, ty;
  logic [DW-1:0]       ax, ay;
  logic                sx, sy;
  logic [SW-1:0]       s_sum;
  logic [B2W-1:0]      b2;
  logic [SPW-1:0]      tgt, nxt;

  // shift-add multiplier
  logic [PW-1:0] mul_a, acc;
  logic [DW-1:0] mul_b;

  // restoring divider
  logic [PW-1:0]  dnum;
  logic [DVW-1:0] drem, ddiv;
  logic [QW-1:0]  dquo;
  logic [CW-1:0]  cnt;

  // square root
  logic [SW-1:0]   sshift;
  logic [RW:0]     srem;
  logic [RW-1:0]   root;

  logic accept, out_free, mul_done, cnt_done;
  logic snap_hit, brake_hit, overshoot;
  logic cfg_wr;

  logic signed [W:0]   dx_c, dy_c;
  logic [2*SPW-1:0]    snap2_c, nxt2_c;
  logic [SPW-1:0]      nxt_c;
  logic [DVW:0]        dtrial;
  logic                dbit;
  logic [RW+2:0]       strial, ssub;
  logic                sbit;
  logic [PW-1:0]       mag_num;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign mul_done = (mul_b == '0);
  assign cnt_done = (cnt == '0);

  // delta to target
  assign dx_c = {tx[W-1], tx} - {pos_x[W-1], pos_x};
  assign dy_c = {ty[W-1], ty} - {pos_y[W-1], pos_y};

  assign snap2_c = snap_distance * snap_distance;
  assign snap_hit = (s_sum <= SW'(snap2_c));
  assign brake_hit = (CMW'(s_sum) < CMW'(b2));

  // speed moves toward target speed by at most accel_step
  always_comb begin
    if (tgt >= spd) begin
      nxt_c = ((tgt - spd) <= accel_step) ? tgt : spd + accel_step;
    end else begin
      nxt_c = ((spd - tgt) <= accel_step) ? tgt : spd - accel_step;
    end
  end
  assign nxt2_c = nxt_c * nxt_c;
  assign overshoot = (CMW'(nxt2_c) >= CMW'(s_sum));

  // one divider step
  assign dtrial = {drem, dnum[PW-1]};
  assign dbit = (dtrial >= {1'b0, ddiv});

  // one root step
  assign strial = {srem, sshift[SW-1:SW-2]};
  assign ssub = {1'b0, root, 2'b01};
  assign sbit = (strial >= ssub);

  // rounded numerator for the axis step
  assign mag_num = acc + PW'(root >> 1);

  function automatic logic signed [W-1:0] step_sat(
    input logic signed [W-1:0] p,
    input logic                neg,
    input logic [QW-1:0]       mag
  );
    logic signed [EW-1:0] sum;
    logic signed [EW-1:0] hi, lo;
    hi = {4'b0000, {(W-1){1'b1}}};
    lo = -hi - EW'(1);
    sum = EW'(p) + (neg ? -$signed(EW'(mag)) : $signed(EW'(mag)));
    if (sum > hi) begin
      step_sat = W'(hi);
    end else if (sum < lo) begin
      step_sat = W'(lo);
    end else begin
      step_sat = W'(sum);
    end
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      eppm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = s_tuser ? eppm_pkg::ST_OUT : eppm_pkg::ST_DELTA;
        end
      end
      eppm_pkg::ST_DELTA: state_next = eppm_pkg::ST_SQX;
      eppm_pkg::ST_SQX: if (mul_done) state_next = eppm_pkg::ST_SQY;
      eppm_pkg::ST_SQY: if (mul_done) state_next = eppm_pkg::ST_TEST;
      eppm_pkg::ST_TEST: begin
        if (snap_hit) begin
          state_next = eppm_pkg::ST_OUT;
        end else if (brake_hit) begin
          state_next = eppm_pkg::ST_TGTMUL;
        end else begin
          state_next = eppm_pkg::ST_SPEED;
        end
      end
      eppm_pkg::ST_TGTMUL: if (mul_done) state_next = eppm_pkg::ST_TGTDIV;
      eppm_pkg::ST_TGTDIV: if (cnt_done) state_next = eppm_pkg::ST_SPEED;
      eppm_pkg::ST_SPEED: begin
        state_next = overshoot ? eppm_pkg::ST_OUT : eppm_pkg::ST_ROOT;
      end
      eppm_pkg::ST_ROOT: if (cnt_done) state_next = eppm_pkg::ST_MULX;
      eppm_pkg::ST_MULX: if (mul_done) state_next = eppm_pkg::ST_DIVX;
      eppm_pkg::ST_DIVX: if (cnt_done) state_next = eppm_pkg::ST_MULY;
      eppm_pkg::ST_MULY: if (mul_done) state_next = eppm_pkg::ST_DIVY;
      eppm_pkg::ST_DIVY: if (cnt_done) state_next = eppm_pkg::ST_OUT;
      eppm_pkg::ST_OUT: if (out_free) state_next = eppm_pkg::ST_IDLE;
      default: state_next = eppm_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs from state
  always_comb begin
    case (state)
      eppm_pkg::ST_IDLE: s_tready = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eppm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_speed <= eppm_pkg::CRUISE_SPEED_RST;
      accel_step <= eppm_pkg::ACCEL_STEP_RST;
      brake_zone <= eppm_pkg::BRAKE_ZONE_RST;
      snap_distance <= eppm_pkg::SNAP_DIST_RST;
    end else if (cfg_wr) begin
      case (eppm_pkg::reg_idx_t'(paddr[3:2]))
        eppm_pkg::REG_CRUISE_SPEED: cruise_speed <= pwdata[SPW-1:0];
        eppm_pkg::REG_ACCEL_STEP: accel_step <= pwdata[SPW-1:0];
        eppm_pkg::REG_BRAKE_ZONE: brake_zone <= pwdata[BZW-1:0];
        eppm_pkg::REG_SNAP_DIST: snap_distance <= pwdata[SPW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (eppm_pkg::reg_idx_t'(paddr[3:2]))
      eppm_pkg::REG_CRUISE_SPEED: prdata = eppm_pkg::CFG_DW'(cruise_speed);
      eppm_pkg::REG_ACCEL_STEP: prdata = eppm_pkg::CFG_DW'(accel_step);
      eppm_pkg::REG_BRAKE_ZONE: prdata = eppm_pkg::CFG_DW'(brake_zone);
      eppm_pkg::REG_SNAP_DIST: prdata = eppm_pkg::CFG_DW'(snap_distance);
      default: prdata = '0;
    endcase
  end

  // position and speed state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      spd <= '0;
    end else begin
      case (state)
        eppm_pkg::ST_IDLE: begin
          if (accept && s_tuser) begin
            pos_x <= s_tdata[W-1:0];
            pos_y <= s_tdata[2*W-1:W];
            spd <= '0;
          end
        end
        eppm_pkg::ST_TEST: begin
          if (snap_hit) begin
            pos_x <= tx;
            pos_y <= ty;
            spd <= '0;
          end
        end
        eppm_pkg::ST_SPEED: begin
          if (overshoot) begin
            pos_x <= tx;
            pos_y <= ty;
            spd <= '0;
          end
        end
        eppm_pkg::ST_DIVX: begin
          if (cnt_done) pos_x <= step_sat(pos_x, sx, dquo);
        end
        eppm_pkg::ST_DIVY: begin
          if (cnt_done) begin
            pos_y <= step_sat(pos_y, sy, dquo);
            spd <= nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      eppm_pkg::ST_IDLE: begin
        tx <= s_tdata[W-1:0];
        ty <= s_tdata[2*W-1:W];
        arrived <= 1'b0;
      end
      eppm_pkg::ST_DELTA: begin
        sx <= dx_c[W];
        sy <= dy_c[W];
        ax <= dx_c[W] ? DW'(-dx_c) : DW'(dx_c);
        ay <= dy_c[W] ? DW'(-dy_c) : DW'(dy_c);
        b2 <= brake_zone * brake_zone;
        mul_a <= dx_c[W] ? PW'(DW'(-dx_c)) : PW'(DW'(dx_c));
        mul_b <= dx_c[W] ? DW'(-dx_c) : DW'(dx_c);
        acc <= '0;
      end
      eppm_pkg::ST_SQX: begin
        if (mul_done) begin
          s_sum <= SW'(acc);
          mul_a <= PW'(ay);
          mul_b <= ay;
          acc <= '0;
        end else begin
          if (mul_b[0]) acc <= acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      eppm_pkg::ST_SQY: begin
        if (mul_done) begin
          s_sum <= s_sum + SW'(acc);
        end else begin
          if (mul_b[0]) acc <= acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      eppm_pkg::ST_TEST: begin
        tgt <= cruise_speed;
        if (snap_hit) arrived <= 1'b1;
        // eased target: cruise_speed * s / brake_zone^2
        mul_a <= PW'(s_sum);
        mul_b <= DW'(cruise_speed);
        acc <= '0;
      end
      eppm_pkg::ST_TGTMUL: begin
        if (mul_done) begin
          dnum <= acc << (PW - SPW);
          drem <= DVW'(acc >> SPW);
          ddiv <= DVW'(b2);
          cnt <= CW'(SPW);
        end else begin
          if (mul_b[0]) acc <= acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      eppm_pkg::ST_TGTDIV: begin
        if (cnt_done) begin
          tgt <= dquo[SPW-1:0];
        end else begin
          drem <= dbit ? DVW'(dtrial - {1'b0, ddiv}) : DVW'(dtrial);
          dnum <= dnum << 1;
          dquo <= {dquo[QW-2:0], dbit};
          cnt <= cnt - CW'(1);
        end
      end
      eppm_pkg::ST_SPEED: begin
        nxt <= nxt_c;
        if (overshoot) arrived <= 1'b1;
        sshift <= s_sum;
        srem <= '0;
        root <= '0;
        cnt <= CW'(RW);
      end
      eppm_pkg::ST_ROOT: begin
        if (cnt_done) begin
          mul_a <= PW'(ax);
          mul_b <= DW'(nxt);
          acc <= '0;
        end else begin
          srem <= sbit ? (RW+1)'(strial - ssub) : (RW+1)'(strial);
          root <= {root[RW-2:0], sbit};
          sshift <= sshift << 2;
          cnt <= cnt - CW'(1);
        end
      end
      eppm_pkg::ST_MULX, eppm_pkg::ST_MULY: begin
        if (mul_done) begin
          // (|delta| * speed + d/2) / d
          dnum <= mag_num << (PW - QW);
          drem <= DVW'(mag_num >> QW);
          ddiv <= DVW'(root);
          cnt <= CW'(QW);
        end else begin
          if (mul_b[0]) acc <= acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      eppm_pkg::ST_DIVX: begin
        if (cnt_done) begin
          mul_a <= PW'(ay);
          mul_b <= DW'(nxt);
          acc <= '0;
        end else begin
          drem <= dbit ? DVW'(dtrial - {1'b0, ddiv}) : DVW'(dtrial);
          dnum <= dnum << 1;
          dquo <= {dquo[QW-2:0], dbit};
          cnt <= cnt - CW'(1);
        end
      end
      eppm_pkg::ST_DIVY: begin
        if (!cnt_done) begin
          drem <= dbit ? DVW'(dtrial - {1'b0, ddiv}) : DVW'(dtrial);
          dnum <= dnum << 1;
          dquo <= {dquo[QW-2:0], dbit};
          cnt <= cnt - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == eppm_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == eppm_pkg::ST_OUT && out_free) begin
      m_tdata <= OTW'({spd, pos_y, pos_x});
      m_tuser <= arrived;
    end
  end

endmodule

>>> tb/sv/eased_point_to_point_mover_tb.sv
// testbench for eased_point_to_point_mover: random and directed steering beats
// checked against an in-bench motion predictor; depends on eppm_pkg and the rtl
`timescale 1ns / 1ps

module eased_point_to_point_mover_tb;

  localparam int CW = eppm_pkg::COORD_WIDTH_DEF;
  localparam int SDW = ((2*CW+7)/8)*8;
  localparam int MDW = ((2*CW+16+7)/8)*8;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic kind;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
  } steer_t;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [15:0] spd;
    logic arr;
  } motion_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [SDW-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [MDW-1:0] m_tdata;
  logic m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [eppm_pkg::CFG_AW-1:0] paddr = '0;
  logic [eppm_pkg::CFG_DW-1:0] pwdata = '0;
  logic [eppm_pkg::CFG_DW-1:0] prdata;
  logic pready;

  always #1 clk = ~clk;

  eased_point_to_point_mover u_top (.*);

  // predictor state and configuration copy
  longint unsigned cfg_cruise, cfg_acc, cfg_brake, cfg_snap;
  longint cur_x, cur_y;
  longint unsigned cur_spd;

  steer_t steer_q[$];
  motion_t motion_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0; // stretch with no idling

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint axis_move(longint dlt, longint unsigned sp, longint unsigned d);
    longint unsigned mag, a;
    a = dlt < 0 ? -dlt : dlt;
    mag = (a * sp + d / 2) / d;
    return dlt < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic motion_t predict_motion(steer_t st);
    motion_t r;
    longint tx, ty, dx, dy;
    longint unsigned ax, ay, s, tgt, b2, nxt;
    tx = st.tx;
    ty = st.ty;
    r.arr = 0;
    if (st.kind) begin
      cur_x = tx; cur_y = ty; cur_spd = 0;
    end else begin
      dx = tx - cur_x;
      dy = ty - cur_y;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      s = ax * ax + ay * ay;
      if (s <= cfg_snap * cfg_snap) begin
        cur_x = tx; cur_y = ty; cur_spd = 0; r.arr = 1;
      end else begin
        tgt = cfg_cruise;
        b2 = cfg_brake * cfg_brake;
        if (s < b2) tgt = (cfg_cruise * s) / b2;
        if (tgt >= cur_spd) nxt = (tgt - cur_spd <= cfg_acc) ? tgt : cur_spd + cfg_acc;
        else nxt = (cur_spd - tgt <= cfg_acc) ? tgt : cur_spd - cfg_acc;
        if (nxt * nxt >= s) begin
          cur_x = tx; cur_y = ty; cur_spd = 0; r.arr = 1;
        end else begin
          cur_x = clamp_coord(cur_x + axis_move(dx, nxt, root_floor(s)));
          cur_y = clamp_coord(cur_y + axis_move(dy, nxt, root_floor(s)));
          cur_spd = nxt & 16'hFFFF;
        end
      end
    end
    r.px = CW'(cur_x);
    r.py = CW'(cur_y);
    r.spd = 16'(cur_spd);
    return r;
  endfunction

  // driver: present queued beats, idle now and then
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (steer_q.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
          s_tvalid <= 1;
          s_tuser <= steer_q[0].kind;
          s_tdata <= {steer_q[0].ty, steer_q[0].tx};
          motion_q.push_back(predict_motion(steer_q.pop_front()));
        end else begin
          s_tvalid <= 0;
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // monitor: compare each output beat with the oldest prediction
  always @(posedge clk) begin
    motion_t got, exp_m;
    if (!rst && m_tvalid && m_tready) begin
      got.px = m_tdata[CW-1:0];
      got.py = m_tdata[2*CW-1:CW];
      got.spd = m_tdata[2*CW+15:2*CW];
      got.arr = m_tuser;
      if (motion_q.size() == 0) begin
        $display("%0t unexpected beat: got %p", $time, got);
        errors++;
      end else begin
        exp_m = motion_q.pop_front();
        if (got !== exp_m) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp_m, got);
          errors++;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[eased_point_to_point_mover] ERROR");
      $finish;
    end
  end

  task automatic apb_write(eppm_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      eppm_pkg::REG_CRUISE_SPEED: cfg_cruise = 64'(val[15:0]);
      eppm_pkg::REG_ACCEL_STEP: cfg_acc = 64'(val[15:0]);
      eppm_pkg::REG_BRAKE_ZONE: cfg_brake = 64'(val[22:0]);
      eppm_pkg::REG_SNAP_DIST: cfg_snap = 64'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic push_steer(logic k, longint x, longint y);
    steer_t st;
    st.kind = k; st.tx = CW'(x); st.ty = CW'(y);
    steer_q.push_back(st);
  endtask

  // wait until every beat has been sent and answered, then let the block settle
  task automatic drain();
    while (steer_q.size() > 0 || motion_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // random coordinate: mostly near the current area, sometimes anywhere
  function automatic longint rand_coord(longint base, int spread);
    if ($urandom_range(9) == 0) return longint'($signed($urandom_range(0, (1 << CW) - 1)) <<< 8) >>> 8;
    return clamp_coord(base + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic random_run(int n, int spread);
    longint gx, gy;
    gx = rand_coord(0, spread * 4);
    gy = rand_coord(0, spread * 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) gx = rand_coord(gx, spread * 4);
      if ($urandom_range(19) == 0) gy = rand_coord(gy, spread * 4);
      // mostly chase a fixed target so speed ramps and the easing zone is reached
      if ($urandom_range(29) == 0) push_steer(1, rand_coord(gx, spread), rand_coord(gy, spread));
      else push_steer(0, gx, gy);
    end
  endtask

  initial begin
    cfg_cruise = 64'(eppm_pkg::CRUISE_SPEED_RST); cfg_acc = 64'(eppm_pkg::ACCEL_STEP_RST);
    cfg_brake = 64'(eppm_pkg::BRAKE_ZONE_RST); cfg_snap = 64'(eppm_pkg::SNAP_DIST_RST);
    cur_x = 0; cur_y = 0; cur_spd = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: extremes, place, snap, saturation, brake easing
    push_steer(0, 0, 0);                       // already on target: snap
    push_steer(0, 8388607, 8388607);           // far corner, cruising
    push_steer(0, -8388608, -8388608);
    push_steer(1, 8388607, -8388608);          // place at extreme
    push_steer(0, -8388608, 8388607);          // longest distance
    push_steer(1, 0, 0);
    push_steer(0, 300, -400);                  // within snap radius: snap
    push_steer(0, 300, -400);
    push_steer(0, 100, 0);                     // within snap radius
    push_steer(1, -5, 7);
    push_steer(0, 4000, 0);
    push_steer(0, 4000, 0);
    drain();

    // zero brake zone, huge speed: overshoot snap and saturation
    apb_write(eppm_pkg::REG_BRAKE_ZONE, 0);
    apb_write(eppm_pkg::REG_CRUISE_SPEED, 16'hFFFF);
    apb_write(eppm_pkg::REG_ACCEL_STEP, 16'hFFFF);
    apb_write(eppm_pkg::REG_SNAP_DIST, 0);
    push_steer(1, 8388000, -8388000);
    push_steer(0, 8388607, -8388608);
    push_steer(0, -8388608, 8388607);
    push_steer(0, 0, 0);
    push_steer(0, 1, 0);
    drain();

    // zero cruise speed and accel, full brake zone, wide snap
    apb_write(eppm_pkg::REG_CRUISE_SPEED, 0);
    apb_write(eppm_pkg::REG_ACCEL_STEP, 0);
    apb_write(eppm_pkg::REG_BRAKE_ZONE, 23'h7FFFFF);
    apb_write(eppm_pkg::REG_SNAP_DIST, 16'hFFFF);
    random_run(10, 1 << 17);
    drain();

    apb_write(eppm_pkg::REG_CRUISE_SPEED, 1536);
    apb_write(eppm_pkg::REG_ACCEL_STEP, 51);
    apb_write(eppm_pkg::REG_BRAKE_ZONE, 7680);
    apb_write(eppm_pkg::REG_SNAP_DIST, 512);
    calm = 1;
    random_run(200, 20000);
    drain();
    calm = 0;
    random_run(250, 20000);
    drain();

    apb_write(eppm_pkg::REG_CRUISE_SPEED, $urandom_range(0, 65535));
    apb_write(eppm_pkg::REG_ACCEL_STEP, $urandom_range(0, 4000));
    apb_write(eppm_pkg::REG_BRAKE_ZONE, $urandom_range(1, 200000));
    apb_write(eppm_pkg::REG_SNAP_DIST, $urandom_range(0, 2000));
    random_run(200, 1 << 18);
    drain();

    apb_write(eppm_pkg::REG_CRUISE_SPEED, $urandom_range(0, 65535));
    apb_write(eppm_pkg::REG_ACCEL_STEP, $urandom_range(0, 65535));
    apb_write(eppm_pkg::REG_BRAKE_ZONE, 1);
    apb_write(eppm_pkg::REG_SNAP_DIST, $urandom_range(0, 65535));
    random_run(180, 1 << 22);
    drain();

    if (errors == 0) begin
      $display("[eased_point_to_point_mover] OK");
    end else begin
      $display("[eased_point_to_point_mover] ERROR");
    end
    $finish;
  end

endmodule
